>>> design/i64d_pkg.sv
// Shared types and constants for the 64-bit divider core.
package i64d_pkg;

    localparam int unsigned FIELD_W = 64;

    typedef enum logic {
        CMD_UNSIGNED = 1'b0,
        CMD_SIGNED   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_div_in;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               divide_by_zero;
    } t_div_out;

endpackage

>>> design/i64d_fifo.sv
// Small register-based queue with push/full and pop/empty sides.
module i64d_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             s_push;
    logic             s_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ s_push;
        n_rd_ptr = r_rd_ptr ^ s_pop;
        n_count  = r_count + {1'b0, s_push} - {1'b0, s_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr)) else $error("queue pointers disagree");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_push && !s_pop) |=> !o_empty) else $error("queue empty after push");
`endif

endmodule

>>> design/i64d_front.sv
// Front end: accept operands, take magnitudes and signs, queue them for the datapath.
module i64d_front #(
    parameter int unsigned W = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  i64d_pkg::t_div_in      i_in,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic [2*W+2:0]         o_op,
    output logic                   o_empty
);
    import i64d_pkg::*;

    logic [W-1:0] s_num;
    logic [W-1:0] s_den;
    logic         s_nneg;
    logic         s_dneg;
    logic [W-1:0] s_nmag;
    logic [W-1:0] s_dmag;
    logic         s_zero;

    always_comb begin
        s_num  = i_in.dividend[W-1:0];
        s_den  = i_in.divisor[W-1:0];
        s_nneg = (t_cmd'(i_in.command) == CMD_SIGNED) && s_num[W-1];
        s_dneg = (t_cmd'(i_in.command) == CMD_SIGNED) && s_den[W-1];
        s_nmag = s_nneg ? (~s_num + W'(1)) : s_num;
        s_dmag = s_dneg ? (~s_den + W'(1)) : s_den;
        s_zero = (s_den == '0);
    end

    i64d_fifo #(.WIDTH(2*W+3)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  ({s_zero, s_nneg, s_nneg ^ s_dneg, s_nmag, s_dmag}),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_op),
        .o_empty (o_empty)
    );

endmodule

>>> design/i64d_back.sv
// Back end: one restoring quotient bit per stage, then sign fixup.
module i64d_back #(
    parameter int unsigned W = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [2*W+2:0]         i_op,
    input  logic                   i_op_empty,
    output logic                   o_op_pop,
    input  logic                   i_res_full,
    output logic                   o_res_push,
    output i64d_pkg::t_div_out     o_res
);
    import i64d_pkg::*;

    logic         r_v    [W];
    logic [W-1:0] r_r    [W];
    logic [W-1:0] r_nq   [W];
    logic [W-1:0] r_den  [W];
    logic         r_negq [W];
    logic         r_nneg [W];
    logic         r_zero [W];
    logic         s_ce;
    logic [W-1:0] s_q;
    logic [W-1:0] s_rem;

    assign s_ce     = !r_v[W-1] || !i_res_full;
    assign o_op_pop = s_ce && !i_op_empty;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic         s_v;
        logic [W-1:0] s_r;
        logic [W-1:0] s_nq;
        logic [W-1:0] s_den;
        logic         s_negq;
        logic         s_nneg;
        logic         s_zero;
        logic [W:0]   s_diff;
        logic [W-1:0] n_r;
        logic [W-1:0] n_nq;

        if (k == 0) begin : g_head
            assign s_v    = !i_op_empty;
            assign s_r    = '0;
            assign s_zero = i_op[2*W+2];
            assign s_nneg = i_op[2*W+1];
            assign s_negq = i_op[2*W];
            assign s_nq   = i_op[2*W-1:W];
            assign s_den  = i_op[W-1:0];
        end else begin : g_body
            assign s_v    = r_v[k-1];
            assign s_r    = r_r[k-1];
            assign s_zero = r_zero[k-1];
            assign s_nneg = r_nneg[k-1];
            assign s_negq = r_negq[k-1];
            assign s_nq   = r_nq[k-1];
            assign s_den  = r_den[k-1];
        end

        always_comb begin
            s_diff = {s_r, s_nq[W-1]} - {1'b0, s_den};
            n_r    = s_diff[W] ? {s_r[W-2:0], s_nq[W-1]} : s_diff[W-1:0];
            n_nq   = {s_nq[W-2:0], !s_diff[W]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (s_ce) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_ce) begin
                r_r[k]    <= n_r;
                r_nq[k]   <= n_nq;
                r_den[k]  <= s_den;
                r_negq[k] <= s_negq;
                r_nneg[k] <= s_nneg;
                r_zero[k] <= s_zero;
            end
        end
    end

    always_comb begin
        s_q   = r_negq[W-1] ? (~r_nq[W-1] + W'(1)) : r_nq[W-1];
        s_rem = r_nneg[W-1] ? (~r_r[W-1] + W'(1)) : r_r[W-1];
        o_res.quotient       = FIELD_W'(s_q);
        o_res.remainder      = FIELD_W'(s_rem);
        o_res.divide_by_zero = r_zero[W-1];
    end

    assign o_res_push = r_v[W-1] && !i_res_full;

endmodule

>>> design/int64_divider_core.sv
// Top level of the pipelined 64-bit restoring divider core.
//   channel | handshake            | payload
//   input   | push / full          | i_in  (command, dividend, divisor)
//   result  | empty / pop          | o_out (quotient, remainder, divide_by_zero)
// One transaction per cycle sustained unless the full result queue stalls the pipeline.
// The quotient pipeline has DATA_WIDTH stages, one bit per stage.
// Synchronous active-low reset empties both queues and the pipeline.
// Result queue full and last stage valid freeze the pipeline; input queue raises full at two.
module int64_divider_core #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  i64d_pkg::t_div_in     i_in,
    output logic                  full,
    input  logic                  pop,
    output i64d_pkg::t_div_out    o_out,
    output logic                  empty
);
    import i64d_pkg::*;

    logic [2*DATA_WIDTH+2:0] s_op;
    logic                    s_op_empty;
    logic                    s_op_pop;
    logic                    s_res_full;
    logic                    s_res_push;
    t_div_out                s_res;

    i64d_front #(.W(DATA_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_in    (i_in),
        .o_full  (full),
        .i_pop   (s_op_pop),
        .o_op    (s_op),
        .o_empty (s_op_empty)
    );

    i64d_back #(.W(DATA_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (s_op),
        .i_op_empty (s_op_empty),
        .o_op_pop   (s_op_pop),
        .i_res_full (s_res_full),
        .o_res_push (s_res_push),
        .o_res      (s_res)
    );

    i64d_fifo #(.WIDTH($bits(t_div_out))) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_push),
        .i_data  (s_res),
        .o_full  (s_res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule
